// ----- rtl/spq3_pkg.sv -----
`default_nettype none
package spq3_pkg;

    // Ring geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_WIDTH   = 16;
    localparam int NUM_CLASSES = 3;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    // Port widths fixed by the interface
    localparam int TAG_PORT_W   = 16;
    localparam int CLASS_PORT_W = 2;
    localparam int FILL_PORT_W  = 5;

    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [FILL_W-1:0]       fill_t;
    typedef logic [TAG_WIDTH-1:0]    tag_t;
    typedef logic [CLASS_PORT_W-1:0] class_t;

    // Operation codes
    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_SERVE = 1'b1
    } func_t;

    // Priority classes
    localparam class_t CLASS_HIGH    = 2'd0;
    localparam class_t CLASS_MIDDLE  = 2'd1;
    localparam class_t CLASS_LOW     = 2'd2;
    localparam class_t CLASS_INVALID = 2'd3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_SERVED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_INVALID = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // Ring pointer advance with wrap at the last entry
    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/strict_priority_three_fifo_core.sv -----
`default_nettype none
// Strict-priority queue of 16-bit item tags in three classes (high, middle,
// low), each held in a 16-entry ring. An add word puts its tag at the tail of
// its class ring, flagging an invalid class or a full ring and dropping the
// tag; a serve word pops the head of the highest-priority non-empty ring or
// reports that nothing waits. Each word returns one result that also carries
// the fill of all three rings after the operation. A word passes through an
// input register and a result register, with the ring access and priority pick
// between them, so one word is accepted every cycle while the result side is
// not stalled.
module strict_priority_three_fifo_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_func,
    input  wire logic [spq3_pkg::TAG_PORT_W-1:0]  s_item_tag,
    input  wire logic [spq3_pkg::CLASS_PORT_W-1:0] s_item_class,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [spq3_pkg::TAG_PORT_W-1:0]       m_served_tag,
    output logic [spq3_pkg::CLASS_PORT_W-1:0]     m_served_class,
    output logic [2:0]                            m_status,
    output logic [spq3_pkg::FILL_PORT_W-1:0]      m_high_fill,
    output logic [spq3_pkg::FILL_PORT_W-1:0]      m_middle_fill,
    output logic [spq3_pkg::FILL_PORT_W-1:0]      m_low_fill
);
    import spq3_pkg::*;

    // Input register
    logic   in_valid_reg;
    func_t  in_func_reg;
    tag_t   in_tag_reg;
    class_t in_class_reg;

    // Result register
    logic                    out_valid_reg;
    logic [TAG_PORT_W-1:0]   out_tag_reg;
    class_t                  out_class_reg;
    status_t                 out_status_reg;
    logic [FILL_PORT_W-1:0]  out_fill_reg [NUM_CLASSES];

    // Queue state
    tag_t  ring_reg [NUM_CLASSES][QUEUE_DEPTH];
    ptr_t  rd_ptr_reg  [NUM_CLASSES];
    ptr_t  wr_ptr_reg  [NUM_CLASSES];
    fill_t fill_reg    [NUM_CLASSES];
    ptr_t  rd_ptr_next [NUM_CLASSES];
    ptr_t  wr_ptr_next [NUM_CLASSES];
    fill_t fill_next   [NUM_CLASSES];

    logic    advance;
    logic    do_write;
    logic    found;
    class_t  sel_class;
    tag_t    sel_tag;
    status_t status_next;

    // Handshake: the input stage moves on whenever the result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_func_reg  <= func_t'(s_func);
            in_tag_reg   <= TAG_WIDTH'(s_item_tag);
            in_class_reg <= s_item_class;
        end
    end

    // Add / serve decision and pointer updates
    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        do_write    = 1'b0;
        found       = 1'b0;
        sel_class   = CLASS_HIGH;
        sel_tag     = '0;
        status_next = ST_EMPTY;
        unique case (in_func_reg)
            FUNC_ADD: begin
                priority if (in_class_reg == CLASS_INVALID) begin
                    status_next = ST_INVALID;
                end else if (fill_reg[in_class_reg] == FILL_W'(QUEUE_DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    do_write                  = 1'b1;
                    wr_ptr_next[in_class_reg] = ptr_inc(wr_ptr_reg[in_class_reg]);
                    fill_next[in_class_reg]   = fill_t'(fill_reg[in_class_reg] + 1'b1);
                    status_next               = ST_ADDED;
                end
            end
            FUNC_SERVE: begin
                // fixed priority pick: lowest class index that holds anything
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    if (!found && fill_reg[c] != '0) begin
                        found          = 1'b1;
                        sel_class      = class_t'(c);
                        sel_tag        = ring_reg[c][rd_ptr_reg[c]];
                        rd_ptr_next[c] = ptr_inc(rd_ptr_reg[c]);
                        fill_next[c]   = fill_t'(fill_reg[c] - 1'b1);
                    end
                end
                if (found) begin
                    status_next = ST_SERVED;
                end
            end
            default: ;
        endcase
    end

    // Ring storage, no reset
    always_ff @(posedge aclk) begin
        if (advance && do_write) begin
            ring_reg[in_class_reg][wr_ptr_reg[in_class_reg]] <= in_tag_reg;
        end
    end

    // Queue control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr_reg[c] <= '0;
                wr_ptr_reg[c] <= '0;
                fill_reg[c]   <= '0;
            end
        end else if (advance) begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_tag_reg    <= TAG_PORT_W'(sel_tag);
            out_class_reg  <= sel_class;
            out_status_reg <= status_next;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                out_fill_reg[c] <= FILL_PORT_W'(32'(fill_next[c]));
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_served_tag   = out_tag_reg;
    assign m_served_class = out_class_reg;
    assign m_status       = out_status_reg;
    assign m_high_fill    = out_fill_reg[CLASS_HIGH];
    assign m_middle_fill  = out_fill_reg[CLASS_MIDDLE];
    assign m_low_fill     = out_fill_reg[CLASS_LOW];

endmodule
`default_nettype wire
